/* hw/rtl/lzss_pkg.sv */
// Shared constants and controller/datapath interface types for the LZSS decompressor.
`timescale 1ns / 1ps

package lzss_pkg;

  localparam int unsigned WindowDepthDef = 4096;
  // write position starts this many entries below the top of the window
  localparam int unsigned StartBackoff   = 18;
  // shortest match is three bytes; the counter holds bytes still to follow
  localparam int unsigned MinMatch       = 3;
  localparam int unsigned CountW         = 5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic restart;    // return parse state and write position to reset values
    logic clr_wr;     // write zero at clear address and advance it
    logic accept;     // input transaction taken this cycle
    logic copy_step;  // write the fetched match byte, emit it, fetch the next
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_high;    // the byte on the input completes a match reference
    logic copy_more;  // more match bytes after the current one
    logic clr_done;   // clear address at the top of the window
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

/* hw/rtl/lzss_ram.sv */
// Generic single-write, single-read RAM with registered read data (read-first).
`timescale 1ns / 1ps

module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/lzss_dpath.sv */
// Datapath: token parsing registers, history window, match copy and output register.
`timescale 1ns / 1ps

module lzss_dpath #(
  parameter int unsigned WINDOW_DEPTH = lzss_pkg::WindowDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lzss_pkg::cmd_t    cmd_i,
  output lzss_pkg::sts_t    sts_o,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              run_end_o
);

  import lzss_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] StartPos = AW'(WINDOW_DEPTH - StartBackoff);
  localparam logic [AW-1:0] LastAddr = AW'(WINDOW_DEPTH - 1);

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  logic [AW-1:0]     wp_q, wp_d;
  logic [7:0]        flag_q, flag_d;
  logic [3:0]        left_q, left_d;
  logic [1:0]        phase_q, phase_d;
  logic [7:0]        low_q, low_d;
  logic [AW-1:0]     src_q, src_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              fwd_q;
  logic [7:0]        fwd_data_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic              is_tok, is_lit, is_low, is_high;
  logic              lit_acc, low_acc, high_acc, flag_acc;
  logic              consume;
  logic [3:0]        left_dec;
  logic [AW-1:0]     match_pos;
  logic [7:0]        ram_rdata, copy_byte;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [7:0]        wr_data;
  logic              out_free;

  assign is_tok  = (phase_q == PH_TOKEN) && (left_q != 4'd0);
  assign is_lit  = is_tok && flag_q[0];
  assign is_low  = is_tok && !flag_q[0];
  assign is_high = (phase_q == PH_HIGH);

  assign lit_acc  = cmd_i.accept && is_lit;
  assign low_acc  = cmd_i.accept && is_low;
  assign high_acc = cmd_i.accept && is_high;
  assign flag_acc = cmd_i.accept && !is_tok && !is_high;
  assign consume  = lit_acc || high_acc;

  assign match_pos = AW'({in_byte_i[7:4], low_q});
  assign left_dec  = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
  assign copy_byte = fwd_q ? fwd_data_q : ram_rdata;
  assign out_free  = !out_valid_q || out_ready_i;

  // window port steering
  always_comb begin
    wr_en   = cmd_i.clr_wr || lit_acc || cmd_i.copy_step;
    wr_addr = cmd_i.clr_wr ? clr_q : wp_q;
    wr_data = cmd_i.clr_wr ? 8'h00 : (lit_acc ? in_byte_i : copy_byte);
    rd_en   = high_acc || (cmd_i.copy_step && (cnt_q != '0));
    rd_addr = high_acc ? match_pos : src_q;
  end

  // parse state and pointers
  always_comb begin
    wp_d    = wp_q;
    flag_d  = flag_q;
    left_d  = left_q;
    phase_d = phase_q;
    low_d   = low_q;
    src_d   = src_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    if (cmd_i.clr_wr) begin
      clr_d = clr_q + AW'(1);
    end
    if (flag_acc) begin
      flag_d  = in_byte_i;
      left_d  = 4'd8;
      phase_d = PH_TOKEN;
    end
    if (low_acc) begin
      low_d   = in_byte_i;
      phase_d = PH_HIGH;
    end
    if (consume) begin
      flag_d  = {1'b0, flag_q[7:1]};
      left_d  = left_dec;
      phase_d = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
    end
    if (lit_acc) begin
      wp_d = wp_q + AW'(1);
    end
    if (high_acc) begin
      src_d = match_pos + AW'(1);
      cnt_d = CountW'(in_byte_i[3:0]) + CountW'(MinMatch - 1);
    end
    if (cmd_i.copy_step) begin
      wp_d = wp_q + AW'(1);
      if (cnt_q != '0) begin
        src_d = src_q + AW'(1);
        cnt_d = cnt_q - CountW'(1);
      end
    end
    if (cmd_i.restart) begin
      wp_d    = StartPos;
      flag_d  = 8'h00;
      left_d  = 4'd0;
      phase_d = PH_FLAG;
      low_d   = 8'h00;
      clr_d   = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (lit_acc) begin
      out_valid_d = 1'b1;
      out_byte_d  = in_byte_i;
      out_last_d  = 1'b1;
    end else if (cmd_i.copy_step) begin
      out_valid_d = 1'b1;
      out_byte_d  = copy_byte;
      out_last_d  = (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= StartPos;
      flag_q      <= 8'h00;
      left_q      <= 4'd0;
      phase_q     <= PH_FLAG;
      low_q       <= 8'h00;
      src_q       <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      flag_q      <= flag_d;
      left_q      <= left_d;
      phase_q     <= phase_d;
      low_q       <= low_d;
      src_q       <= src_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a read landing on the address written in the same cycle takes the new byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en) begin
      fwd_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      fwd_data_q <= wr_data;
    end
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rdata)
  );

  assign sts_o.is_high   = is_high;
  assign sts_o.copy_more = (cnt_q != '0);
  assign sts_o.clr_done  = (clr_q == LastAddr);
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = out_last_q;

endmodule

/* hw/rtl/lzss_ctrl.sv */
// Controller: window clear sweep, input acceptance and match copy sequencing.
`timescale 1ns / 1ps

module lzss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  lzss_pkg::sts_t sts_i,
  output lzss_pkg::cmd_t cmd_o
);

  import lzss_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_COPY  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       last_pend_q, last_pend_d;
  logic       acc;

  assign in_ready_o = (state_q == ST_RUN) && sts_i.out_free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    last_pend_d = last_pend_q;
    cmd_o       = '0;
    cmd_o.accept = acc;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (acc) begin
          if (sts_i.is_high) begin
            state_d     = ST_COPY;
            last_pend_d = in_last_i;
          end else if (in_last_i) begin
            state_d       = ST_CLEAR;
            cmd_o.restart = 1'b1;
          end
        end
      end
      ST_COPY: begin
        if (sts_i.out_free) begin
          cmd_o.copy_step = 1'b1;
          if (!sts_i.copy_more) begin
            if (last_pend_q) begin
              state_d       = ST_CLEAR;
              cmd_o.restart = 1'b1;
            end else begin
              state_d = ST_RUN;
            end
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        cmd_o.restart = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      last_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_pend_q <= last_pend_d;
    end
  end

  a_no_accept_outside_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !in_ready_o)
    else $error("input taken while clearing or copying");

  a_copy_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.copy_step |-> sts_i.out_free)
    else $error("match byte would overwrite a pending result");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sts_i.clr_done) |=> (state_q == ST_RUN))
    else $error("clear sweep did not hand over to run");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_wr |-> !(cmd_o.accept || cmd_o.copy_step))
    else $error("window write collides with clear sweep");

endmodule

/* hw/rtl/lzss_window_decompressor_top.sv */
// Top level of the LZSS decompressor with a 4096-byte history window.
`timescale 1ns / 1ps

// Takes one compressed byte per transaction and emits decompressed bytes. Flag
// bytes, match low bytes and literals are taken without holding the input off;
// a literal gives one result. A match high byte is taken and then holds the
// input off while its 3 to 18 match bytes are copied, paced by the single read
// port of the window RAM. Output backpressure stalls both. After reset and
// after the byte marked tlast has been handled, a clearing pass zeroes the
// window one entry per cycle, all WINDOW_DEPTH (4096) entries, with
// s_axis_tready low. m_axis_tlast marks the last result caused by one input byte.
module lzss_window_decompressor_top #(
  parameter int unsigned WINDOW_DEPTH = lzss_pkg::WindowDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // last_in
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // run_end
);

  import lzss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lzss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzss_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .run_end_o   (m_axis_tlast)
  );

endmodule
